[src/tbcs_pkg.sv]
// Shared types, constants and brush tables for the touch brush canvas stamper.
// No dependencies; every other file imports this package.
package tbcs_pkg;

  // Canvas geometry
  localparam int GRID    = 28;
  localparam int CELLS   = GRID * GRID;
  localparam int ADDR_W  = 10;
  localparam int IDX_W   = 5;
  localparam int COORD_W = 12;
  localparam int LEVEL_W = 8;
  localparam int SHADE_W = 3;
  localparam int STEP_W  = 4;

  // Mirror bases of the two axes
  localparam int COL_BASE = 30;
  localparam int ROW_BASE = 40;

  // Level arithmetic
  localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW   = 8'd128;
  localparam logic [LEVEL_W-1:0] LEVEL_MID   = 8'd192;
  localparam logic [LEVEL_W-1:0] GAIN_LOW    = 8'd64;
  localparam logic [LEVEL_W-1:0] GAIN_MID    = 8'd63;
  localparam logic [LEVEL_W-1:0] LEVEL_Q1    = 8'd64;

  // Shade codes
  typedef logic [SHADE_W-1:0] shade_t;
  localparam shade_t SHADE_64    = 3'd0;
  localparam shade_t SHADE_128   = 3'd1;
  localparam shade_t SHADE_192   = 3'd2;
  localparam shade_t SHADE_255   = 3'd3;
  localparam shade_t SHADE_OTHER = 3'd4;

  // Edge classes of a row or column index
  typedef logic [1:0] edge_t;
  localparam edge_t EDGE_MID  = 2'd0;
  localparam edge_t EDGE_LOW  = 2'd1;
  localparam edge_t EDGE_HIGH = 2'd2;

  // One brush entry: row and column offset, each biased by one
  typedef struct packed {
    logic [1:0] dr;
    logic [1:0] dc;
  } ofs_t;

  // Brush entry lists, nine nibbles {dr,dc}, entry 0 in the low nibble
  localparam logic [35:0] BR_MID_MID   = 36'h89A625104;
  localparam logic [35:0] BR_MID_LOW   = 36'h0006125A9;
  localparam logic [35:0] BR_MID_HIGH  = 36'h000410589;
  localparam logic [35:0] BR_LOW_MID   = 36'h00069A584;
  localparam logic [35:0] BR_LOW_LOW   = 36'h0000095A6;
  localparam logic [35:0] BR_LOW_HIGH  = 36'h000009854;
  localparam logic [35:0] BR_HIGH_MID  = 36'h000162504;
  localparam logic [35:0] BR_HIGH_LOW  = 36'h000006521;
  localparam logic [35:0] BR_HIGH_HIGH = 36'h000004501;

  // Number of cells the brush touches after clipping
  function automatic logic [STEP_W-1:0] brush_len(edge_t er, edge_t ec);
    if (er == EDGE_MID && ec == EDGE_MID) begin
      return STEP_W'(9);
    end else if (er == EDGE_MID || ec == EDGE_MID) begin
      return STEP_W'(6);
    end else begin
      return STEP_W'(4);
    end
  endfunction

  // Offset pair of brush entry k for the given edge classes
  function automatic ofs_t brush_ofs(edge_t er, edge_t ec, logic [STEP_W-1:0] k);
    logic [35:0] list;
    case ({er, ec})
      {EDGE_MID, EDGE_MID}:   list = BR_MID_MID;
      {EDGE_MID, EDGE_LOW}:   list = BR_MID_LOW;
      {EDGE_MID, EDGE_HIGH}:  list = BR_MID_HIGH;
      {EDGE_LOW, EDGE_MID}:   list = BR_LOW_MID;
      {EDGE_LOW, EDGE_LOW}:   list = BR_LOW_LOW;
      {EDGE_LOW, EDGE_HIGH}:  list = BR_LOW_HIGH;
      {EDGE_HIGH, EDGE_MID}:  list = BR_HIGH_MID;
      {EDGE_HIGH, EDGE_LOW}:  list = BR_HIGH_LOW;
      {EDGE_HIGH, EDGE_HIGH}: list = BR_HIGH_HIGH;
      default:                list = '0;
    endcase
    if (k > STEP_W'(8)) begin
      return '0;
    end
    return ofs_t'(list[{k, 2'b00} +: 4]);
  endfunction

  // Edge class of an index
  function automatic edge_t edge_of(logic [IDX_W-1:0] v);
    if (v == '0) begin
      return EDGE_LOW;
    end else if (v == IDX_W'(GRID - 1)) begin
      return EDGE_HIGH;
    end else begin
      return EDGE_MID;
    end
  endfunction

  // Shade code of a level
  function automatic shade_t shade_of(logic [LEVEL_W-1:0] lv);
    case (lv)
      LEVEL_Q1:   return SHADE_64;
      LEVEL_LOW:  return SHADE_128;
      LEVEL_MID:  return SHADE_192;
      LEVEL_FULL: return SHADE_255;
      default:    return SHADE_OTHER;
    endcase
  endfunction

endpackage

[src/tbcs_touch_if.sv]
// Touch point channel: valid/ready handshake carrying one (x, y) item.
// Depends on tbcs_pkg.
interface tbcs_touch_if;
  import tbcs_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] touch_x;
  logic [COORD_W-1:0] touch_y;

  modport source (output valid, touch_x, touch_y, input ready);
  modport sink   (input valid, touch_x, touch_y, output ready);
endinterface

[src/tbcs_cell_if.sv]
// Cell update channel: valid/ready handshake carrying one updated canvas cell.
// Depends on tbcs_pkg.
interface tbcs_cell_if;
  import tbcs_pkg::*;

  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   cell_row;
  logic [IDX_W-1:0]   cell_col;
  logic [LEVEL_W-1:0] level;
  logic [SHADE_W-1:0] shade;
  logic               last;

  modport source (output valid, cell_row, cell_col, level, shade, last, input ready);
  modport sink   (input valid, cell_row, cell_col, level, shade, last, output ready);
endinterface

[src/touch_brush_canvas_stamper.sv]
// Top level of the touch brush canvas stamper: canvas memory, brush sequencer
// and output register. Depends on tbcs_pkg, tbcs_touch_if, tbcs_cell_if, tbcs_axis_map.
//
//   channel  dir  payload                                  handshake
//   touch    in   touch_x[11:0], touch_y[11:0]             valid/ready
//   update   out  cell_row, cell_col, level, shade, last   valid/ready
//
// An item is mapped, then compared with the previous cell, then stamped with n canvas
// reads (n = 9, 6 or 4 by edge) issued one per cycle on the canvas read port while the
// update channel is not stalled; each write-back lands as the output register loads.
// A touch on the previous cell gives no update.
// After reset all 784 canvas cells are cleared; touch.ready stays low meanwhile.
// A stalled update channel holds the pending read data and pauses new reads.
module touch_brush_canvas_stamper #(
  parameter int CELL_SCALE = 8
) (
  input  logic        clk,
  input  logic        rst,
  tbcs_touch_if.sink  touch,
  tbcs_cell_if.source update
);
  import tbcs_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_CHECK = 4'b0100,
    S_STAMP = 4'b1000
  } state_t;

  state_t state;

  logic [ADDR_W-1:0]  clr_addr;
  logic [IDX_W-1:0]   map_row;
  logic [IDX_W-1:0]   map_col;
  logic [IDX_W-1:0]   row;
  logic [IDX_W-1:0]   col;
  logic [IDX_W-1:0]   prev_row;
  logic [IDX_W-1:0]   prev_col;
  edge_t              er;
  edge_t              ec;
  logic [STEP_W-1:0]  len;
  logic [STEP_W-1:0]  cnt;

  // Read stage
  logic               pend;
  logic [IDX_W-1:0]   pend_r;
  logic [IDX_W-1:0]   pend_c;
  logic               pend_centre;
  logic               pend_last;
  logic [LEVEL_W-1:0] rdata;

  // Output register
  logic               out_valid;
  logic [IDX_W-1:0]   out_row;
  logic [IDX_W-1:0]   out_col;
  logic [LEVEL_W-1:0] out_level;
  shade_t             out_shade;
  logic               out_last;

  logic               accept;
  logic               issue;
  logic               load;
  ofs_t               ofs;
  logic [IDX_W-1:0]   rr;
  logic [IDX_W-1:0]   cc;
  logic [ADDR_W-1:0]  raddr;
  logic [ADDR_W-1:0]  waddr;
  logic [LEVEL_W-1:0] lv_new;

  logic [LEVEL_W-1:0] canvas [CELLS];

  // Coordinate mapping, mirrored per axis
  tbcs_axis_map #(.CELL_SCALE(CELL_SCALE), .BASE(COL_BASE)) u_map_col (
    .clk   (clk),
    .en    (accept),
    .coord (touch.touch_x),
    .idx   (map_col)
  );

  tbcs_axis_map #(.CELL_SCALE(CELL_SCALE), .BASE(ROW_BASE)) u_map_row (
    .clk   (clk),
    .en    (accept),
    .coord (touch.touch_y),
    .idx   (map_row)
  );

  assign touch.ready = (state == S_IDLE);
  assign accept      = touch.valid && touch.ready;

  // Brush entry address and handshake of the read stage
  always_comb begin
    ofs   = brush_ofs(er, ec, cnt);
    rr    = row + IDX_W'(ofs.dr) - IDX_W'(1);
    cc    = col + IDX_W'(ofs.dc) - IDX_W'(1);
    raddr = ADDR_W'(rr) * ADDR_W'(GRID) + ADDR_W'(cc);
    waddr = ADDR_W'(pend_r) * ADDR_W'(GRID) + ADDR_W'(pend_c);
    load  = pend && (!out_valid || update.ready);
    issue = (state == S_STAMP) && (cnt != len) && (!pend || load);
  end

  // New level of the cell being written back
  always_comb begin
    if (!pend_centre && rdata <= LEVEL_LOW) begin
      lv_new = rdata + GAIN_LOW;
    end else if (!pend_centre && rdata <= LEVEL_MID) begin
      lv_new = rdata + GAIN_MID;
    end else begin
      lv_new = LEVEL_FULL;
    end
  end

  // Canvas memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      canvas[clr_addr] <= '0;
    end else if (load) begin
      canvas[waddr] <= lv_new;
    end
    if (issue) begin
      rdata <= canvas[raddr];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      prev_row <= '0;
      prev_col <= '0;
      cnt      <= '0;
      pend     <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (map_row == prev_row && map_col == prev_col) begin
            state <= S_IDLE;
          end else begin
            prev_row <= map_row;
            prev_col <= map_col;
            cnt      <= '0;
            state    <= S_STAMP;
          end
        end
        S_STAMP: begin
          if (issue) begin
            cnt  <= cnt + STEP_W'(1);
            pend <= 1'b1;
          end else if (load) begin
            pend <= 1'b0;
          end
          if (load && pend_last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Stamp context, latched once per touch
  always_ff @(posedge clk) begin
    if (state == S_CHECK) begin
      row <= map_row;
      col <= map_col;
      er  <= edge_of(map_row);
      ec  <= edge_of(map_col);
      len <= brush_len(edge_of(map_row), edge_of(map_col));
    end
  end

  // Read stage tags
  always_ff @(posedge clk) begin
    if (issue) begin
      pend_r      <= rr;
      pend_c      <= cc;
      pend_centre <= (ofs.dr == 2'd1) && (ofs.dc == 2'd1);
      pend_last   <= (cnt + STEP_W'(1)) == len;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (update.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_row   <= pend_r;
      out_col   <= pend_c;
      out_level <= lv_new;
      out_shade <= shade_of(lv_new);
      out_last  <= pend_last;
    end
  end

  assign update.valid    = out_valid;
  assign update.cell_row = out_row;
  assign update.cell_col = out_col;
  assign update.level   = out_level;
  assign update.shade   = out_shade;
  assign update.last    = out_last;

  // Checks
  a_no_update_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !out_valid)
    else $error("update offered during canvas clear");

  a_pend_only_in_stamp: assert property (@(posedge clk) disable iff (rst)
    pend |-> state == S_STAMP)
    else $error("read pending outside stamping");

  a_cnt_bounded: assert property (@(posedge clk) disable iff (rst)
    state == S_STAMP |-> cnt <= len)
    else $error("brush step past its length");

  a_last_ends_stamp: assert property (@(posedge clk) disable iff (rst)
    load && pend_last |=> state == S_IDLE)
    else $error("stamp did not end after last cell");

  a_addr_in_range: assert property (@(posedge clk) disable iff (rst)
    issue |-> raddr < ADDR_W'(CELLS))
    else $error("canvas read address out of range");

endmodule

[src/tbcs_axis_map.sv]
// Maps one touch coordinate to a mirrored, clamped canvas index.
// Depends on tbcs_pkg. Quotient registered on en, index valid the next cycle.
module tbcs_axis_map #(
  parameter int CELL_SCALE = 8,
  parameter int BASE       = 30
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [tbcs_pkg::COORD_W-1:0] coord,
  output logic [tbcs_pkg::IDX_W-1:0]   idx
);
  import tbcs_pkg::*;

  // Division by a constant as a multiply by a rounded-up reciprocal;
  // exact for 12-bit coordinates and scales up to 64.
  localparam int SHIFT  = 24;
  localparam int RECIP_W = SHIFT + 1;
  localparam int PROD_W  = COORD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** SHIFT) + CELL_SCALE - 1) / CELL_SCALE);
  localparam logic [7:0] BASE_V = 8'(BASE);

  logic [PROD_W-1:0]  prod;
  logic [COORD_W-1:0] quot;
  logic [7:0]         v;
  logic [IDX_W-1:0]   v_clamp;

  assign prod = PROD_W'(coord) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      quot <= prod[SHIFT +: COORD_W];
    end
  end

  // Mirror modulo 256, clamp to 1..28, then shift to 0..27
  always_comb begin
    v = BASE_V - quot[7:0];
    if (v == 8'd0) begin
      v_clamp = IDX_W'(1);
    end else if (v > 8'(GRID)) begin
      v_clamp = IDX_W'(GRID);
    end else begin
      v_clamp = v[IDX_W-1:0];
    end
    idx = v_clamp - IDX_W'(1);
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for touch_brush_canvas_stamper: a directed touch table, then
// random strokes, each accepted touch checked against a canvas predictor in this file.
// Depends on tbcs_pkg, tbcs_touch_if, tbcs_cell_if and the stamper RTL.
module tb_top;
  import tbcs_pkg::*;

  localparam int CELL_SCALE     = 8;
  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 6;
  localparam int RANDOM_ITEMS   = 425;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int N_DIRECTED     = 25;

  // One expected cell update
  typedef struct {
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [LEVEL_W-1:0] level;
    shade_t             shade;
    logic               last;
  } cell_upd_t;

  // One touch of the directed table; typed rows carry the update count and
  // the first update, the rest rely on the predictor
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               typed;
    logic [3:0]         n;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [LEVEL_W-1:0] level;
    shade_t             shade;
  } touch_vec_t;

  // Stamping order per edge class pair, index = row class * 3 + column class
  // (mid, first, last). Each entry is {row offset + 1, column offset + 1}.
  localparam logic [3:0] STAMP_ORDER [9][9] = '{
    '{{2'd1, 2'd0}, {2'd0, 2'd0}, {2'd0, 2'd1}, {2'd1, 2'd1}, {2'd0, 2'd2},
      {2'd1, 2'd2}, {2'd2, 2'd2}, {2'd2, 2'd1}, {2'd2, 2'd0}},
    '{{2'd2, 2'd1}, {2'd2, 2'd2}, {2'd1, 2'd1}, {2'd0, 2'd2}, {2'd0, 2'd1},
      {2'd1, 2'd2}, 4'h0, 4'h0, 4'h0},
    '{{2'd2, 2'd1}, {2'd2, 2'd0}, {2'd1, 2'd1}, {2'd0, 2'd0}, {2'd0, 2'd1},
      {2'd1, 2'd0}, 4'h0, 4'h0, 4'h0},
    '{{2'd1, 2'd0}, {2'd2, 2'd0}, {2'd1, 2'd1}, {2'd2, 2'd2}, {2'd2, 2'd1},
      {2'd1, 2'd2}, 4'h0, 4'h0, 4'h0},
    '{{2'd1, 2'd2}, {2'd2, 2'd2}, {2'd1, 2'd1}, {2'd2, 2'd1}, 4'h0,
      4'h0, 4'h0, 4'h0, 4'h0},
    '{{2'd1, 2'd0}, {2'd1, 2'd1}, {2'd2, 2'd0}, {2'd2, 2'd1}, 4'h0,
      4'h0, 4'h0, 4'h0, 4'h0},
    '{{2'd1, 2'd0}, {2'd0, 2'd0}, {2'd1, 2'd1}, {2'd0, 2'd2}, {2'd1, 2'd2},
      {2'd0, 2'd1}, 4'h0, 4'h0, 4'h0},
    '{{2'd0, 2'd1}, {2'd0, 2'd2}, {2'd1, 2'd1}, {2'd1, 2'd2}, 4'h0,
      4'h0, 4'h0, 4'h0, 4'h0},
    '{{2'd0, 2'd1}, {2'd0, 2'd0}, {2'd1, 2'd1}, {2'd1, 2'd0}, 4'h0,
      4'h0, 4'h0, 4'h0, 4'h0}
  };
  localparam int STAMP_COUNT [9] = '{9, 6, 6, 6, 4, 4, 6, 4, 4};

  logic clk = 1'b0;
  logic rst;

  tbcs_touch_if touch ();
  tbcs_cell_if  update ();

  touch_brush_canvas_stamper #(
    .CELL_SCALE (CELL_SCALE)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .touch  (touch),
    .update (update)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state
  logic [LEVEL_W-1:0] canvas_model [GRID * GRID];
  logic [IDX_W-1:0]   last_row;
  logic [IDX_W-1:0]   last_col;

  cell_upd_t pending_updates [$];
  cell_upd_t due_upd;
  int        fail_count  = 0;
  int        idle_cycles = 0;
  logic      steady      = 1'b0;
  logic      hold_req    = 1'b0;

  // Directed touches: reset cell, corners, edges, wrap and clamp, saturation
  touch_vec_t directed_touches [N_DIRECTED] = '{
    // cell (0,0) right after reset: nothing
    '{12'd240, 12'd320, 1'b1, 4'd0, 5'd0, 5'd0, 8'd0, SHADE_64},
    // origin maps to corner (27,27)
    '{12'd0, 12'd0, 1'b1, 4'd4, 5'd26, 5'd27, 8'd64, SHADE_64},
    '{12'd0, 12'd0, 1'b1, 4'd0, 5'd0, 5'd0, 8'd0, SHADE_64},
    // max coordinates wrap, clamp to the same corner
    '{12'd4095, 12'd4095, 1'b1, 4'd0, 5'd0, 5'd0, 8'd0, SHADE_64},
    // corner (0,0)
    '{12'd240, 12'd320, 1'b1, 4'd4, 5'd0, 5'd1, 8'd64, SHADE_64},
    // top row, column 1: old centre stays full
    '{12'd224, 12'd320, 1'b1, 4'd6, 5'd0, 5'd0, 8'd255, SHADE_255},
    // interior (13,13)
    '{12'd128, 12'd208, 1'b1, 4'd9, 5'd13, 5'd12, 8'd64, SHADE_64},
    '{12'd135, 12'd215, 1'b1, 4'd0, 5'd0, 5'd0, 8'd0, SHADE_64},
    // toggle between neighbors until the shared cells saturate
    '{12'd136, 12'd208, 1'b0, 4'd0, 5'd0, 5'd0, 8'd0, SHADE_64},
    '{12'd128, 12'd208, 1'b0, 4'd0, 5'd0, 5'd0, 8'd0, SHADE_64},
    '{12'd136, 12'd208, 1'b0, 4'd0, 5'd0, 5'd0, 8'd0, SHADE_64},
    '{12'd128, 12'd208, 1'b0, 4'd0, 5'd0, 5'd0, 8'd0, SHADE_64},
    '{12'd136, 12'd208, 1'b0, 4'd0, 5'd0, 5'd0, 8'd0, SHADE_64},
    '{12'd128, 12'd208, 1'b0, 4'd0, 5'd0, 5'd0, 8'd0, SHADE_64},
    // edges: last column, first column, first row, last row
    '{12'd0, 12'd208, 1'b0, 4'd0, 5'd0, 5'd0, 8'd0, SHADE_64},
    '{12'd240, 12'd208, 1'b0, 4'd0, 5'd0, 5'd0, 8'd0, SHADE_64},
    '{12'd128, 12'd320, 1'b0, 4'd0, 5'd0, 5'd0, 8'd0, SHADE_64},
    '{12'd128, 12'd0, 1'b0, 4'd0, 5'd0, 5'd0, 8'd0, SHADE_64},
    // remaining corners
    '{12'd0, 12'd320, 1'b0, 4'd0, 5'd0, 5'd0, 8'd0, SHADE_64},
    '{12'd240, 12'd0, 1'b0, 4'd0, 5'd0, 5'd0, 8'd0, SHADE_64},
    // subtraction wraps to exactly zero on both axes
    '{12'd2288, 12'd2368, 1'b0, 4'd0, 5'd0, 5'd0, 8'd0, SHADE_64},
    // wrap to 255 on x
    '{12'd2296, 12'd4095, 1'b0, 4'd0, 5'd0, 5'd0, 8'd0, SHADE_64},
    // x clamps high, y lands on v = 1
    '{12'd8, 12'd312, 1'b0, 4'd0, 5'd0, 5'd0, 8'd0, SHADE_64},
    '{12'd4095, 12'd0, 1'b0, 4'd0, 5'd0, 5'd0, 8'd0, SHADE_64},
    '{12'd0, 12'd4095, 1'b0, 4'd0, 5'd0, 5'd0, 8'd0, SHADE_64}
  };

  // Mirrored, wrapped and clamped cell index of one axis
  function automatic logic [IDX_W-1:0] axis_cell(logic [COORD_W-1:0] coord, int base);
    int v;
    v = (base - int'(coord) / CELL_SCALE) & 255;
    if (v == 0) begin
      v = 1;
    end
    if (v >= GRID + 1) begin
      v = GRID;
    end
    return IDX_W'(v - 1);
  endfunction

  function automatic edge_t edge_class(logic [IDX_W-1:0] v);
    if (v == '0) begin
      return EDGE_LOW;
    end else if (v == IDX_W'(GRID - 1)) begin
      return EDGE_HIGH;
    end
    return EDGE_MID;
  endfunction

  function automatic shade_t shade_code(logic [LEVEL_W-1:0] lv);
    case (lv)
      8'd64:   return SHADE_64;
      8'd128:  return SHADE_128;
      8'd192:  return SHADE_192;
      8'd255:  return SHADE_255;
      default: return SHADE_OTHER;
    endcase
  endfunction

  // Stamp the brush for one touch into the canvas copy, returning the updates
  function automatic void stamp_touch(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                      ref cell_upd_t ups[$]);
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [3:0]         ofs;
    logic [LEVEL_W-1:0] lv;
    cell_upd_t          u;
    int                 cls;
    int                 r;
    int                 c;
    ups.delete();
    col = axis_cell(x, COL_BASE);
    row = axis_cell(y, ROW_BASE);
    if (row == last_row && col == last_col) begin
      return;
    end
    last_row = row;
    last_col = col;
    cls = int'(edge_class(row)) * 3 + int'(edge_class(col));
    for (int k = 0; k < STAMP_COUNT[cls]; k++) begin
      ofs = STAMP_ORDER[cls][k];
      r   = int'(row) + int'(ofs[3:2]) - 1;
      c   = int'(col) + int'(ofs[1:0]) - 1;
      lv  = canvas_model[r * GRID + c];
      // centre goes full; neighbors step up a quarter and saturate
      if (r == int'(row) && c == int'(col)) begin
        lv = 8'd255;
      end else if (lv <= 8'd128) begin
        lv = lv + 8'd64;
      end else if (lv <= 8'd192) begin
        lv = lv + 8'd63;
      end else begin
        lv = 8'd255;
      end
      canvas_model[r * GRID + c] = lv;
      u.row   = IDX_W'(r);
      u.col   = IDX_W'(c);
      u.level = lv;
      u.shade = shade_code(lv);
      u.last  = (k + 1 == STAMP_COUNT[cls]);
      ups.push_back(u);
    end
  endfunction

  function automatic void check_field(string name, int due, int got);
    if (due != got) begin
      $error("%s: expected %0d, got %0d", name, due, got);
      fail_count++;
    end
  endfunction

  // Offer one touch, with random gaps; predict at acceptance
  task automatic send_touch(input touch_vec_t tv);
    cell_upd_t ups [$];
    while (!steady && $urandom_range(99) < 33) begin
      touch.valid <= 1'b0;
      @(negedge clk);
    end
    touch.valid   <= 1'b1;
    touch.touch_x <= tv.x;
    touch.touch_y <= tv.y;
    @(posedge clk);
    while (!touch.ready) begin
      @(posedge clk);
    end
    stamp_touch(tv.x, tv.y, ups);
    // a typed zero count drops the updates; otherwise typed rows override the first update
    if (tv.typed) begin
      if (tv.n == 4'd0) begin
        ups.delete();
      end else if (ups.size() > 0) begin
        ups[0].row   = tv.row;
        ups[0].col   = tv.col;
        ups[0].level = tv.level;
        ups[0].shade = tv.shade;
        ups[0].last  = (tv.n == 4'd1);
      end
    end
    foreach (ups[k]) begin
      pending_updates.push_back(ups[k]);
    end
    @(negedge clk);
  endtask

  // Update receiver: random stalls, plus one long hold-off on request
  initial begin
    update.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        update.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      update.ready <= steady || ($urandom_range(99) >= 33);
    end
  end

  // Update checker
  always @(posedge clk) begin
    if (update.valid && update.ready) begin
      if (pending_updates.size() == 0) begin
        $error("unexpected cell update: row %0d col %0d level %0d",
               update.cell_row, update.cell_col, update.level);
        fail_count++;
      end else begin
        due_upd = pending_updates.pop_front();
        check_field("cell_row", due_upd.row, update.cell_row);
        check_field("cell_col", due_upd.col, update.cell_col);
        check_field("level", due_upd.level, update.level);
        check_field("shade", due_upd.shade, update.shade);
        check_field("last", due_upd.last, update.last);
      end
    end
  end

  // Watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((touch.valid && touch.ready) || (update.valid && update.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Stimulus
  initial begin
    touch_vec_t tv;
    int         item_no;
    int         mode;
    int         cur_row;
    int         cur_col;
    rst           = 1'b1;
    touch.valid   = 1'b0;
    touch.touch_x = '0;
    touch.touch_y = '0;
    foreach (canvas_model[i]) begin
      canvas_model[i] = '0;
    end
    last_row = '0;
    last_col = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_touch(directed_touches[i]);
    end

    // Random part: mostly strokes across neighboring cells, some jumps,
    // same-cell jitter and raw full-range coordinates
    tv      = '0;
    item_no = 0;
    cur_row = 13;
    cur_col = 13;
    while (item_no < RANDOM_ITEMS) begin
      steady = (item_no >= 200 && item_no < 300);
      if (item_no == 60) begin
        hold_req = 1'b1;
      end
      mode = $urandom_range(99);
      if (mode < 80) begin
        if (mode < 55) begin
          cur_row = cur_row + int'($urandom_range(2)) - 1;
          cur_col = cur_col + int'($urandom_range(2)) - 1;
          if (cur_row < 0) cur_row = 0;
          if (cur_row > GRID - 1) cur_row = GRID - 1;
          if (cur_col < 0) cur_col = 0;
          if (cur_col > GRID - 1) cur_col = GRID - 1;
        end else if (mode < 70) begin
          cur_row = int'($urandom_range(GRID - 1));
          cur_col = int'($urandom_range(GRID - 1));
        end
        // otherwise jitter inside the current cell
        tv.x = COORD_W'((COL_BASE - 1 - cur_col) * CELL_SCALE +
                        int'($urandom_range(CELL_SCALE - 1)));
        tv.y = COORD_W'((ROW_BASE - 1 - cur_row) * CELL_SCALE +
                        int'($urandom_range(CELL_SCALE - 1)));
      end else begin
        tv.x = COORD_W'($urandom);
        tv.y = COORD_W'($urandom);
      end
      send_touch(tv);
      item_no++;
    end
    touch.valid <= 1'b0;

    while (pending_updates.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
